/* sv/btt_pkg.sv */
// ----------------------------------------------------------------------------
// btt_pkg: shared types and constants of the buffer table translation core
// Table geometry, field widths, command and status codes, and the structs
// that run between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package btt_pkg;

  // Table geometry (BLOCK_ENTRIES is a power of two)
  localparam int BLOCK_ENTRIES = 32;
  localparam int MAX_BLOCKS    = 64;
  localparam int PAGE_BITS     = 12;
  localparam int TABLE_SIZE    = BLOCK_ENTRIES * MAX_BLOCKS;

  localparam int EntW  = $clog2(BLOCK_ENTRIES);
  localparam int BlkW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int SlotW = BlkW + EntW;
  localparam int CntW  = $clog2(MAX_BLOCKS + 1);

  // Field widths
  localparam int CommandW  = 2;
  localparam int BlockNumW = 6;
  localparam int EntryNumW = 5;
  localparam int AddrW     = 64;
  localparam int PageIdxW  = 20;
  localparam int StatusW   = 3;
  localparam int NewBlkW   = 6;
  localparam int TransW    = 64;
  localparam int PagesW    = 32;
  localparam int OrderW    = 4;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MAP_MODE   = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_PAGE_ORDER = 1'd1;

  typedef enum logic [CommandW-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_SET    = 2'd2,
    CMD_LOOKUP = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_BAD_BLOCK = 3'd2,
    ST_BAD_ENTRY = 3'd3,
    ST_NO_FREE   = 3'd4
  } status_e;

  typedef struct packed {
    logic [CommandW-1:0]  command;
    logic [BlockNumW-1:0] block_number;
    logic [EntryNumW-1:0] entry_number;
    logic [AddrW-1:0]     frame_address;
    logic [PageIdxW-1:0]  page_index;
  } cmd_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [NewBlkW-1:0] new_block;
    logic [TransW-1:0]  translated;
    logic [PagesW-1:0]  pages_in_use;
  } rsp_t;

  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

/* sv/btt_cmd_if.sv */
// ----------------------------------------------------------------------------
// btt_cmd_if: command channel
// Valid/ready channel that carries one table command per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface btt_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [btt_pkg::CommandW-1:0]  command;
  logic [btt_pkg::BlockNumW-1:0] block_number;
  logic [btt_pkg::EntryNumW-1:0] entry_number;
  logic [btt_pkg::AddrW-1:0]     frame_address;
  logic [btt_pkg::PageIdxW-1:0]  page_index;

  modport source (output valid, command, block_number, entry_number, frame_address,
                  page_index, input ready);
  modport sink   (input valid, command, block_number, entry_number, frame_address,
                  page_index, output ready);
endinterface

`default_nettype wire

/* sv/btt_rsp_if.sv */
// ----------------------------------------------------------------------------
// btt_rsp_if: response channel
// Valid/ready channel that carries one result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface btt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [btt_pkg::StatusW-1:0] status;
  logic [btt_pkg::NewBlkW-1:0] new_block;
  logic [btt_pkg::TransW-1:0]  translated;
  logic [btt_pkg::PagesW-1:0]  pages_in_use;

  modport source (output valid, status, new_block, translated, pages_in_use, input ready);
  modport sink   (input valid, status, new_block, translated, pages_in_use, output ready);
endinterface

`default_nettype wire

/* sv/btt_cfg_if.sv */
// ----------------------------------------------------------------------------
// btt_cfg_if: configuration write channel
// Valid/ready channel that carries one register write per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface btt_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [btt_pkg::CfgIdxW-1:0]  index;
  logic [btt_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/buffer_table_translation_core.sv */
// A command is captured in idle and committed in the execute state; its response
//   is registered at commit. A new command is taken only after the last commits;
//   each reads the entry memory and written-bit row in its accept cycle.
// A stalled response holds the commit step until the register frees up.
// Reset clears block counters, page count and per-block valid bits, and sets
//   map_mode to 1 and page_order to 0; the entry memory is not swept.
// ----------------------------------------------------------------------------
// buffer_table_translation_core: block-structured page translation table
// Allocates and frees blocks, sets entries and translates page indexes.
// ----------------------------------------------------------------------------
`default_nettype none

module buffer_table_translation_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  btt_cmd_if.sink    cmd_i,
  btt_rsp_if.source  rsp_o,
  btt_cfg_if.sink    cfg_i
);

  btt_pkg::cmd_t    cmd;
  btt_pkg::rsp_t    rsp;
  btt_pkg::cfg_wr_t cfg;
  btt_pkg::ctrl_t   ctrl;
  btt_pkg::stat_t   stat;
  logic             in_ready;
  logic             rsp_valid;

  // Pack channel payloads
  assign cmd.command       = cmd_i.command;
  assign cmd.block_number  = cmd_i.block_number;
  assign cmd.entry_number  = cmd_i.entry_number;
  assign cmd.frame_address = cmd_i.frame_address;
  assign cmd.page_index    = cmd_i.page_index;

  assign cfg.we    = cfg_i.valid;
  assign cfg.index = cfg_i.index;
  assign cfg.data  = cfg_i.data;
  assign cfg_i.ready = 1'b1;

  assign cmd_i.ready = in_ready;

  btt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (in_ready),
    .ctrl_o     (ctrl),
    .stat_i     (stat)
  );

  btt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_i       (cfg),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_o       (rsp)
  );

  // Drive the response channel
  assign rsp_o.valid        = rsp_valid;
  assign rsp_o.status       = rsp.status;
  assign rsp_o.new_block    = rsp.new_block;
  assign rsp_o.translated   = rsp.translated;
  assign rsp_o.pages_in_use = rsp.pages_in_use;

endmodule

`default_nettype wire

/* sv/btt_ctrl.sv */
// ----------------------------------------------------------------------------
// btt_ctrl: command sequencer
// Takes one command, lets the datapath read the tables, then commits the
// result once the response register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module btt_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output btt_pkg::ctrl_t      ctrl_o,
  input  btt_pkg::stat_t      stat_i
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  // Accept in idle; commit when the response register can take the beat
  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    ctrl_o.capture = 1'b0;
    ctrl_o.commit  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        ctrl_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctrl_o.commit = stat_i.out_free;
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A captured command is always followed by the execute step
  a_capture_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.capture |=> (state_q == ST_EXEC))
    else $error("capture not followed by execute");

endmodule

`default_nettype wire

/* sv/btt_dp.sv */
// ----------------------------------------------------------------------------
// btt_dp: translation datapath
// Holds the entry memory, the per-block written bits, the block and page
// counters, the configuration registers and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module btt_dp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  btt_pkg::cmd_t       cmd_i,
  input  btt_pkg::cfg_wr_t    cfg_i,
  input  btt_pkg::ctrl_t      ctrl_i,
  output btt_pkg::stat_t      stat_o,
  output logic                rsp_valid_o,
  input  wire logic           rsp_ready_i,
  output btt_pkg::rsp_t       rsp_o
);

  localparam int EntW  = btt_pkg::EntW;
  localparam int BlkW  = btt_pkg::BlkW;
  localparam int SlotW = btt_pkg::SlotW;
  localparam int CntW  = btt_pkg::CntW;
  localparam int PIW   = btt_pkg::PageIdxW;
  localparam int BE    = btt_pkg::BLOCK_ENTRIES;

  // Memories: entry values and one row of written bits per block
  logic [btt_pkg::AddrW-1:0] entry_mem [btt_pkg::TABLE_SIZE];
  logic [BE-1:0]             written_mem [btt_pkg::MAX_BLOCKS];

  // Configuration
  logic                       mode_q;
  logic [btt_pkg::OrderW-1:0] order_q;

  // Counters and row valid bits
  logic [CntW-1:0]               alloc_q, alloc_d, freed_q, freed_d;
  logic [btt_pkg::PagesW-1:0]    used_q, used_d;
  logic [btt_pkg::MAX_BLOCKS-1:0] rowv_all_q, rowv_all_d;

  // Captured command and read data
  btt_pkg::cmd_e                 cmd_q;
  logic [btt_pkg::BlockNumW-1:0] blk_q;
  logic [btt_pkg::EntryNumW-1:0] ent_q;
  logic [btt_pkg::AddrW-1:0]     addr_q;
  logic [EntW-1:0]               lent_q;
  logic [BlkW-1:0]               row_q;
  logic [PIW-1:0]                sub_q;
  logic                          lk_bad_q;
  logic                          rowv_q;
  logic [BE-1:0]                 wrow_q;
  logic [btt_pkg::AddrW-1:0]     edata_q;

  // Response register
  logic          rsp_valid_q;
  btt_pkg::rsp_t rsp_q, rsp_d;

  // Lookup decode at capture
  logic [PIW-1:0]  pshift, bnum, lk_sub;
  logic [EntW-1:0] lk_ent;
  logic [BlkW-1:0] row_rd;
  logic [SlotW-1:0] slot_rd;
  logic            lk_bad;
  btt_pkg::cmd_e   cmd_in;

  assign cmd_in  = btt_pkg::cmd_e'(cmd_i.command);
  assign pshift  = cmd_i.page_index >> order_q;
  assign bnum    = pshift >> EntW;
  assign lk_ent  = EntW'(pshift);
  assign lk_sub  = cmd_i.page_index & ~({PIW{1'b1}} << order_q);
  assign lk_bad  = 32'(bnum) >= 32'(alloc_q);
  assign row_rd  = (cmd_in == btt_pkg::CMD_LOOKUP) ? BlkW'(bnum) : BlkW'(cmd_i.block_number);
  assign slot_rd = {BlkW'(bnum), lk_ent};

  // Capture command fields
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q    <= cmd_in;
      blk_q    <= cmd_i.block_number;
      ent_q    <= cmd_i.entry_number;
      addr_q   <= cmd_i.frame_address;
      lent_q   <= lk_ent;
      row_q    <= row_rd;
      sub_q    <= lk_sub;
      lk_bad_q <= lk_bad;
      rowv_q   <= rowv_all_q[row_rd];
    end
  end

  // Commit-step decode
  logic                      set_ok, row_we, ent_we, clear_all;
  logic [BE-1:0]             row_wdata;
  logic [SlotW-1:0]          slot_wr;
  logic [btt_pkg::AddrW-1:0] ent_wdata;
  logic [btt_pkg::PagesW:0]  used_sum;
  logic [btt_pkg::TransW-1:0] sub_off;

  assign slot_wr   = {row_q, EntW'(ent_q)};
  assign ent_wdata = mode_q ? addr_q : (addr_q >> btt_pkg::PAGE_BITS);
  assign row_wdata = (rowv_q ? wrow_q : '0) | (BE'(1) << EntW'(ent_q));
  assign used_sum  = {1'b0, used_q} + ((btt_pkg::PagesW + 1)'(1) << order_q);
  assign sub_off   = mode_q ? (btt_pkg::TransW'(sub_q) << btt_pkg::PAGE_BITS)
                            : btt_pkg::TransW'(sub_q);
  assign set_ok    = (32'(blk_q) < 32'(alloc_q)) && (32'(ent_q) < 32'(BE));

  // Execute the command
  always_comb begin
    alloc_d      = alloc_q;
    freed_d      = freed_q;
    used_d       = used_q;
    rowv_all_d   = rowv_all_q;
    row_we       = 1'b0;
    ent_we       = 1'b0;
    clear_all    = 1'b0;
    rsp_d.status     = btt_pkg::ST_OK;
    rsp_d.new_block  = '0;
    rsp_d.translated = '0;
    case (cmd_q)
      btt_pkg::CMD_ALLOC: begin
        if (32'(alloc_q) >= 32'(btt_pkg::MAX_BLOCKS)) begin
          rsp_d.status = btt_pkg::ST_FULL;
        end else begin
          rsp_d.new_block = btt_pkg::NewBlkW'(alloc_q);
          alloc_d         = alloc_q + CntW'(1);
        end
      end
      btt_pkg::CMD_FREE: begin
        if (freed_q >= alloc_q) begin
          rsp_d.status = btt_pkg::ST_NO_FREE;
        end else if (freed_q + CntW'(1) == alloc_q) begin
          clear_all = 1'b1;
          alloc_d   = '0;
          freed_d   = '0;
          used_d    = '0;
        end else begin
          freed_d = freed_q + CntW'(1);
        end
      end
      btt_pkg::CMD_SET: begin
        if (32'(blk_q) >= 32'(alloc_q)) begin
          rsp_d.status = btt_pkg::ST_BAD_BLOCK;
        end else if (!set_ok) begin
          rsp_d.status = btt_pkg::ST_BAD_ENTRY;
        end else begin
          ent_we = 1'b1;
          row_we = 1'b1;
          used_d = used_sum[btt_pkg::PagesW] ? '1 : used_sum[btt_pkg::PagesW-1:0];
        end
      end
      btt_pkg::CMD_LOOKUP: begin
        if (lk_bad_q) begin
          rsp_d.status = btt_pkg::ST_BAD_BLOCK;
        end else if (!(rowv_q && wrow_q[lent_q])) begin
          rsp_d.status = btt_pkg::ST_BAD_ENTRY;
        end else begin
          rsp_d.translated = edata_q + sub_off;
        end
      end
      default: begin
        rsp_d.status = btt_pkg::ST_OK;
      end
    endcase
    if (clear_all) begin
      rowv_all_d = '0;
    end else if (row_we) begin
      rowv_all_d[row_q] = 1'b1;
    end
    rsp_d.pages_in_use = used_d;
  end

  // Memory ports: read at capture, write at commit
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      wrow_q  <= written_mem[row_rd];
      edata_q <= entry_mem[slot_rd];
    end
    if (ctrl_i.commit && row_we) begin
      written_mem[row_q] <= row_wdata;
    end
    if (ctrl_i.commit && ent_we) begin
      entry_mem[slot_wr] <= ent_wdata;
    end
  end

  // Counters, row valid bits and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_q    <= '0;
      freed_q    <= '0;
      used_q     <= '0;
      rowv_all_q <= '0;
      mode_q     <= 1'b1;
      order_q    <= '0;
    end else begin
      if (ctrl_i.commit) begin
        alloc_q    <= alloc_d;
        freed_q    <= freed_d;
        used_q     <= used_d;
        rowv_all_q <= rowv_all_d;
      end
      if (cfg_i.we) begin
        case (cfg_i.index)
          btt_pkg::CFG_MAP_MODE:   mode_q  <= cfg_i.data[0];
          btt_pkg::CFG_PAGE_ORDER: order_q <= cfg_i.data[btt_pkg::OrderW-1:0];
          default: begin
            mode_q <= mode_q;
          end
        endcase
      end
    end
  end

  // Response register: load on commit, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (ctrl_i.commit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      rsp_q <= rsp_d;
    end
  end

  assign stat_o.out_free = !rsp_valid_q || rsp_ready_i;
  assign rsp_valid_o     = rsp_valid_q;
  assign rsp_o           = rsp_q;

  a_freed_le_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    freed_q <= alloc_q)
    else $error("more blocks freed than allocated");

  a_alloc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(alloc_q) <= 32'(btt_pkg::MAX_BLOCKS))
    else $error("block count above table size");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.commit |-> (!rsp_valid_q || rsp_ready_i))
    else $error("commit over a pending response");

endmodule

`default_nettype wire
